// ----- rtl/core/htdp_pkg.sv -----
// Shared types for the hull-trick dp engine.
// No dependencies; used by htdp_ctrl, htdp_dpath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package htdp_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_WT,
    ST_SRCH_EV,
    ST_EVAL,
    ST_DP,
    ST_TOP_RD,
    ST_TOP_WT,
    ST_TOP_HI,
    ST_TOP_EV,
    ST_PUSH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic srch_init;
    logic srch_rd;
    logic srch_step;
    logic lo_rd;
    logic eval;
    logic dp;
    logic top_rd;
    logic top_ev;
    logic top_hi;
    logic pop;
    logic push;
    logic push_base;
    logic set_ovf;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic srch_done;
    logic slope_low;
    logic survives;
    logic slope_eq;
    logic cnt_zero;
    logic cnt_full;
  } stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/htdp_if.sv -----
// Valid/ready channel interfaces for input and result words.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface htdp_in_if;
  logic        valid;
  logic        ready;
  logic        first_item;
  logic [29:0] rect_width;
  logic [29:0] rect_height;
  logic [59:0] rect_cost;
  modport source(output valid, first_item, rect_width, rect_height, rect_cost, input ready);
  modport sink(input valid, first_item, rect_width, rect_height, rect_cost, output ready);
endinterface

interface htdp_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] dp_value;
  logic        [62:0] best_so_far;
  logic               overflow;
  modport source(output valid, dp_value, best_so_far, overflow, input ready);
  modport sink(input valid, dp_value, best_so_far, overflow, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/htdp_ctrl.sv -----
// Sequencer for search, evaluation, pop and push of one word.
// Depends on htdp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module htdp_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            in_first,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire htdp_pkg::stat_t st,
  output htdp_pkg::cmd_t       cmd
);
  htdp_pkg::state_t state_r, state_nxt;
  logic busy;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= htdp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd = '0;
    busy = 1'b1;
    case (state_r)
      htdp_pkg::ST_IDLE: begin
        busy = !rst_n;
        if (in_valid && rst_n) begin
          cmd.load = 1'b1;
          cmd.clear = in_first;
          state_nxt = htdp_pkg::ST_SRCH_RD;
        end
      end
      htdp_pkg::ST_SRCH_RD: begin
        cmd.srch_init = 1'b1;
        state_nxt = htdp_pkg::ST_SRCH_WT;
      end
      htdp_pkg::ST_SRCH_WT: begin
        if (st.srch_done) begin
          cmd.lo_rd = 1'b1;
          state_nxt = htdp_pkg::ST_EVAL;
        end else begin
          cmd.srch_rd = 1'b1;
          state_nxt = htdp_pkg::ST_SRCH_EV;
        end
      end
      htdp_pkg::ST_SRCH_EV: begin
        cmd.srch_step = 1'b1;
        state_nxt = htdp_pkg::ST_SRCH_WT;
      end
      htdp_pkg::ST_EVAL: begin
        cmd.eval = 1'b1;
        state_nxt = htdp_pkg::ST_DP;
      end
      htdp_pkg::ST_DP: begin
        cmd.dp = 1'b1;
        state_nxt = htdp_pkg::ST_TOP_RD;
      end
      htdp_pkg::ST_TOP_RD: begin
        cmd.top_rd = 1'b1;
        state_nxt = htdp_pkg::ST_TOP_WT;
      end
      htdp_pkg::ST_TOP_WT: begin
        if (st.slope_low) state_nxt = htdp_pkg::ST_OUT;
        else begin
          cmd.top_ev = 1'b1;
          state_nxt = htdp_pkg::ST_TOP_HI;
        end
      end
      htdp_pkg::ST_TOP_HI: begin
        cmd.top_hi = 1'b1;
        state_nxt = htdp_pkg::ST_TOP_EV;
      end
      htdp_pkg::ST_TOP_EV: begin
        if (st.survives) begin
          if (st.slope_eq) state_nxt = htdp_pkg::ST_OUT;
          else if (st.cnt_full) begin
            cmd.set_ovf = 1'b1;
            state_nxt = htdp_pkg::ST_OUT;
          end else state_nxt = htdp_pkg::ST_PUSH;
        end else if (st.cnt_zero) begin
          cmd.push_base = 1'b1;
          state_nxt = htdp_pkg::ST_OUT;
        end else begin
          cmd.pop = 1'b1;
          state_nxt = htdp_pkg::ST_TOP_RD;
        end
      end
      htdp_pkg::ST_PUSH: begin
        cmd.push = 1'b1;
        state_nxt = htdp_pkg::ST_OUT;
      end
      htdp_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = htdp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = htdp_pkg::ST_IDLE;
    endcase
  end

  assign in_ready  = !busy;
  assign out_valid = out_valid_r;
endmodule
`default_nettype wire

// ----- rtl/core/htdp_dpath.sv -----
// Envelope stack memories, search registers and wide arithmetic.
// Depends on htdp_pkg; driven by htdp_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module htdp_dpath #(
  parameter int HULL_DEPTH = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire htdp_pkg::cmd_t     cmd,
  output htdp_pkg::stat_t         st,
  input  wire logic        [29:0] in_w,
  input  wire logic        [29:0] in_h,
  input  wire logic        [59:0] in_c,
  output logic signed      [63:0] dp_o,
  output logic             [62:0] best_o,
  output logic                    ovf_o
);
  localparam int AW = (HULL_DEPTH > 1) ? $clog2(HULL_DEPTH) : 1;
  localparam int CW = $clog2(HULL_DEPTH + 1);
  localparam logic signed [63:0] SMAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SMIN = {1'b1, {63{1'b0}}};

  logic        [29:0] mem_m [HULL_DEPTH];
  logic signed [63:0] mem_b [HULL_DEPTH];
  logic signed [63:0] mem_n [HULL_DEPTH];
  logic        [30:0] mem_d [HULL_DEPTH];

  logic        [29:0] rd_m_r;
  logic signed [63:0] rd_b_r, rd_n_r;
  logic        [30:0] rd_d_r;
  logic        [AW-1:0] rd_a;

  logic [CW-1:0] cnt_r;
  logic [AW-1:0] lo_r, hi_r, mid;
  logic [29:0] w_r, h_r;
  logic [59:0] c_r;
  logic signed [63:0] env_r, dp_r, best_r;
  logic ovf_r;
  logic top_zero_r, surv_r;

  logic [AW:0] mid_sum;
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r} + {{AW{1'b0}}, 1'b1};
  assign mid = mid_sum[AW:1];
  logic [AW-1:0] top_a;
  assign top_a = AW'(cnt_r - CW'(1));

  always_comb begin
    rd_a = top_a;
    if (cmd.srch_rd) rd_a = mid;
    else if (cmd.lo_rd || cmd.srch_init) rd_a = lo_r;
  end

  logic rd_en;
  assign rd_en = cmd.srch_rd || cmd.top_rd || cmd.srch_init || cmd.lo_rd;

  logic wipe;
  assign wipe = cmd.clear || !rst_n;

  logic wr_en;
  logic [AW-1:0] wr_a;
  logic signed [63:0] wr_n;
  logic [30:0] wr_d;
  logic signed [64:0] ndiff;
  assign ndiff = {rd_b_r[63], rd_b_r} - {dp_r[63], dp_r};
  always_comb begin
    wr_en = cmd.push || cmd.push_base || wipe;
    wr_a  = cmd.push ? AW'(cnt_r) : '0;
    if (ndiff > 65'sd0 && ndiff[64:63] != 2'b00) wr_n = SMAX;
    else if (ndiff < 65'sd0 && ndiff[64:63] != 2'b11) wr_n = SMIN;
    else wr_n = ndiff[63:0];
    wr_d = {1'b0, w_r} - {1'b0, rd_m_r};
    if (!cmd.push) begin
      wr_n = '0;
      wr_d = 31'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_m[wr_a] <= wipe ? 30'd0 : w_r;
      mem_b[wr_a] <= wipe ? 64'sd0 : dp_r;
      mem_n[wr_a] <= wr_n;
      mem_d[wr_a] <= wr_d;
    end
    if (rd_en) begin
      rd_m_r <= mem_m[rd_a];
      rd_b_r <= mem_b[rd_a];
      rd_n_r <= mem_n[rd_a];
      rd_d_r <= mem_d[rd_a];
    end
  end

  // query compare: n <= -h*d
  logic signed [95:0] qd;
  assign qd = -($signed({1'b0, h_r}) * $signed({1'b0, rd_d_r}));
  logic q_ok;
  assign q_ok = ($signed({{32{rd_n_r[63]}}, rd_n_r}) <= qd);

  // envelope and dp sums
  logic signed [60:0] qm;
  assign qm = -($signed({1'b0, h_r}) * $signed({1'b0, rd_m_r}));
  logic signed [65:0] env_sum;
  assign env_sum = {{5{qm[60]}}, qm} + {{2{rd_b_r[63]}}, rd_b_r};
  logic signed [63:0] env_sat;
  always_comb begin
    if (env_sum > $signed({{2{1'b0}}, SMAX})) env_sat = SMAX;
    else if (env_sum < $signed({{2{1'b1}}, SMIN})) env_sat = SMIN;
    else env_sat = env_sum[63:0];
  end
  logic signed [61:0] wh;
  assign wh = $signed({2'b00, 60'(w_r) * 60'(h_r)});
  logic signed [65:0] dp_sum;
  assign dp_sum = {{4{wh[61]}}, wh} - {6'd0, c_r} + {{2{env_r[63]}}, env_r};
  logic signed [63:0] dp_sat;
  always_comb begin
    if (dp_sum > $signed({{2{1'b0}}, SMAX})) dp_sat = SMAX;
    else if (dp_sum < $signed({{2{1'b1}}, SMIN})) dp_sat = SMIN;
    else dp_sat = dp_sum[63:0];
  end

  // dominance: (sb-b)*d > (m-sm)*n, low 32 bits of the operands first, then the high parts
  logic [30:0] mdiff;
  assign mdiff = {1'b0, w_r} - {1'b0, rd_m_r};
  logic signed [64:0] pb_lo, pn_lo, pb_hi;
  logic signed [63:0] pn_hi;
  assign pb_lo = $signed({1'b0, ndiff[31:0]}) * $signed({1'b0, rd_d_r});
  assign pn_lo = $signed({1'b0, rd_n_r[31:0]}) * $signed({1'b0, mdiff});
  assign pb_hi = $signed(ndiff[64:32]) * $signed({1'b0, rd_d_r});
  assign pn_hi = $signed(rd_n_r[63:32]) * $signed({1'b0, mdiff});
  logic signed [65:0] acc_r, hi_diff;
  assign hi_diff = {pb_hi[64], pb_hi} - {{2{pn_hi[63]}}, pn_hi};
  logic signed [97:0] tot;
  assign tot = {hi_diff, 32'd0} + {{32{acc_r[65]}}, acc_r};
  logic dom;
  assign dom = !tot[97] && (tot != '0);
  logic surv_v;
  always_comb begin
    if (top_zero_r)
      surv_v = (rd_m_r < w_r) || (rd_m_r == w_r && rd_b_r > dp_r);
    else surv_v = dom;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= CW'(1);
      best_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        w_r <= in_w; h_r <= in_h; c_r <= in_c; ovf_r <= 1'b0;
        if (cmd.clear) begin
          cnt_r <= CW'(1); best_r <= '0;
        end
      end
      if (cmd.srch_init) begin
        lo_r <= '0; hi_r <= top_a;
      end
      if (cmd.srch_step) begin
        if (q_ok) lo_r <= mid;
        else hi_r <= mid - AW'(1);
      end
      if (cmd.eval) env_r <= env_sat;
      if (cmd.dp) begin
        dp_r <= dp_sat;
        if (dp_sat > best_r) best_r <= dp_sat;
      end
      if (cmd.top_rd) top_zero_r <= (top_a == '0);
      if (cmd.top_ev) acc_r <= {pb_lo[64], pb_lo} - {pn_lo[64], pn_lo};
      if (cmd.top_hi) surv_r <= surv_v;
      if (cmd.pop) cnt_r <= cnt_r - CW'(1);
      if (cmd.push) cnt_r <= cnt_r + CW'(1);
      if (cmd.push_base) cnt_r <= CW'(1);
      if (cmd.set_ovf) ovf_r <= 1'b1;
    end
  end

  logic eq_r;
  always_ff @(posedge clk) eq_r <= (rd_m_r == w_r);

  logic signed [63:0] dp_out_r;
  logic        [62:0] best_out_r;
  logic               ovf_out_r;
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      dp_out_r   <= dp_r;
      best_out_r <= best_r[62:0];
      ovf_out_r  <= ovf_r;
    end
  end

  // lo is read when the search ends, so eval uses the registered read data in the next state
  assign st.srch_done = (lo_r >= hi_r);
  assign st.slope_low = (w_r < rd_m_r);
  assign st.survives  = surv_r;
  assign st.slope_eq  = eq_r;
  assign st.cnt_zero  = (cnt_r == CW'(1));
  assign st.cnt_full  = (cnt_r >= CW'(HULL_DEPTH));

  assign dp_o   = dp_out_r;
  assign best_o = best_out_r;
  assign ovf_o  = ovf_out_r;
endmodule
`default_nettype wire

// ----- rtl/core/hull_trick_dp_max_engine_core.sv -----
// Top level of the hull-trick dp engine: controller plus datapath.
// Depends on htdp_pkg, htdp_if, htdp_ctrl, htdp_dpath.
//
//  channel | dir | word
//  in_     | in  | first_item, rect_width, rect_height, rect_cost
//  out_    | out | dp_value, best_so_far, overflow
//
// One word at a time: a search of up to ceil(log2(lines)) steps, evaluation and
// the dp sum, then top lines are popped until one survives the new line, then the
// push unless slopes tie or the stack is full; a width below the top slope skips
// tests and push. Reset (rst_n low, synchronous) leaves one line (0,0) and best
// zero. The result holds in an output register until out_ready; the next word is
// taken meanwhile and only waits at the end if that register is still full.
`timescale 1ns / 1ps
`default_nettype none
module hull_trick_dp_max_engine_core #(
  parameter int HULL_DEPTH = 1024
) (
  input wire logic clk,
  input wire logic rst_n,
  htdp_in_if.sink  in_ch,
  htdp_out_if.source out_ch
);
  htdp_pkg::cmd_t  cmd;
  htdp_pkg::stat_t st;

  htdp_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_first(in_ch.first_item),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .st, .cmd
  );

  htdp_dpath #(.HULL_DEPTH(HULL_DEPTH)) u_dpath (
    .clk, .rst_n, .cmd, .st,
    .in_w(in_ch.rect_width), .in_h(in_ch.rect_height), .in_c(in_ch.rect_cost),
    .dp_o(out_ch.dp_value), .best_o(out_ch.best_so_far), .ovf_o(out_ch.overflow)
  );
endmodule
`default_nettype wire

// ----- rtl/core/htdp_chk.sv -----
// Port-level checks for the hull-trick dp engine, bound to the top level.
// Depends on hull_trick_dp_max_engine_core.
`timescale 1ns / 1ps
`default_nettype none
module htdp_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [62:0] best
);
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready)) else $error("result without a finished word");
  a_nodrop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(best)) else $error("result changed while waiting");
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("word taken while busy");
endmodule

bind hull_trick_dp_max_engine_core htdp_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .best(out_ch.best_so_far)
);
`default_nettype wire

// ----- tb/sv/hull_trick_dp_max_engine_core_test.sv -----
// Testbench for hull_trick_dp_max_engine_core: drives rectangle words and checks
// dp, running best and overflow against an in-bench envelope predictor.
// Depends on htdp_if and hull_trick_dp_max_engine_core (and through it htdp_pkg) from the RTL.
`timescale 1ns / 1ps

class hull_tracker;
  localparam int DEPTH = 1024;

  typedef struct {
    longint     dp;
    bit [62:0]  best;
    bit         ovf;
  } chain_result_t;

  longint        slope [DEPTH];
  longint        icpt [DEPTH];
  longint        brk_num [DEPTH];
  longint        brk_den [DEPTH];
  int unsigned   lines;
  longint        best;
  chain_result_t pending [$];
  int            errors;

  function new();
    clear();
    errors = 0;
  endfunction

  function void clear();
    slope[0] = 0;
    icpt[0] = 0;
    brk_num[0] = 0;
    brk_den[0] = 1;
    lines = 1;
    best = 0;
  endfunction

  function longint clip64(logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (v < -66'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return v[63:0];
  endfunction

  function longint add_sat(longint a, longint b);
    logic signed [65:0] x, y;
    x = a;
    y = b;
    return clip64(x + y);
  endfunction

  function longint sub_sat(longint a, longint b);
    logic signed [65:0] x, y;
    x = a;
    y = b;
    return clip64(x - y);
  endfunction

  function bit top_holds(int unsigned i, longint m, longint b);
    logic signed [127:0] sb, d, nb, dm, bn, lhs, rhs;
    if (i == 0) return slope[0] < m || (slope[0] == m && icpt[0] > b);
    sb = icpt[i];
    d = brk_den[i];
    nb = b;
    dm = m - slope[i];
    bn = brk_num[i];
    lhs = sb * d - nb * d;
    rhs = dm * bn;
    return lhs > rhs;
  endfunction

  function bit push_line(longint m, longint b);
    int unsigned i;
    if (m < slope[lines - 1]) return 0;
    while (lines > 0) begin
      i = lines - 1;
      if (top_holds(i, m, b)) begin
        if (slope[i] == m) return 0;
        if (lines >= DEPTH) return 1;
        slope[lines] = m;
        icpt[lines] = b;
        brk_num[lines] = sub_sat(icpt[i], b);
        brk_den[lines] = m - slope[i];
        lines++;
        return 0;
      end
      lines--;
    end
    slope[0] = m;
    icpt[0] = b;
    brk_num[0] = 0;
    brk_den[0] = 1;
    lines = 1;
    return 0;
  endfunction

  function longint envelope_at(longint q);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = lines - 1;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (brk_num[mid] <= q * brk_den[mid]) lo = mid;
      else hi = mid - 1;
    end
    return add_sat(q * slope[lo], icpt[lo]);
  endfunction

  function void note_rect(bit first, bit [29:0] w, bit [29:0] h, bit [59:0] cost);
    chain_result_t r;
    longint wl, hl, cl;
    wl = w;
    hl = h;
    cl = cost;
    if (first) clear();
    r.dp = add_sat(wl * hl - cl, envelope_at(-hl));
    if (r.dp > best) best = r.dp;
    r.ovf = push_line(wl, r.dp);
    r.best = best[62:0];
    pending.insert(pending.size(), r);
  endfunction

  function void check_result(longint dp, bit [62:0] bst, bit ovf);
    chain_result_t r;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result word dp=%0d best=%0d ovf=%0b", $time, dp, bst, ovf);
      errors++;
      return;
    end
    r = pending.pop_front();
    if (r.dp != dp) begin
      $display("%0t: dp_value expected %0d actual %0d", $time, r.dp, dp);
      errors++;
    end
    if (r.best != bst) begin
      $display("%0t: best_so_far expected %0d actual %0d", $time, r.best, bst);
      errors++;
    end
    if (r.ovf != ovf) begin
      $display("%0t: overflow expected %0b actual %0b", $time, r.ovf, ovf);
      errors++;
    end
  endfunction
endclass

module hull_trick_dp_max_engine_core_test;
  logic clk = 0;
  logic rst_n = 0;
  bit   quiet = 0;
  int   stall_left = 0;
  hull_tracker model = new();

  htdp_in_if  in_ch();
  htdp_out_if out_ch();

  hull_trick_dp_max_engine_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      model.check_result(out_ch.dp_value, out_ch.best_so_far, out_ch.overflow);
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!quiet && rst_n && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_rect(bit first, bit [29:0] w, bit [29:0] h, bit [59:0] cost);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.first_item <= first;
    in_ch.rect_width <= w;
    in_ch.rect_height <= h;
    in_ch.rect_cost <= cost;
    do @(posedge clk); while (!in_ch.ready);
    model.note_rect(first, w, h, cost);
  endtask

  task automatic run_chain(int n, int step, int hmax, int cmax, bit wide);
    bit [29:0] w;
    bit [29:0] h;
    bit [59:0] c;
    w = 30'($urandom_range(0, step));
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 19) == 0 && w > 0) begin
        send_rect(0, 30'($urandom_range(0, w - 1)), 30'($urandom_range(0, hmax)),
                  60'($urandom_range(0, cmax)));
        continue;
      end
      if (w > 30'h3FFF_FFFF - step) w = 30'h3FFF_FFFF;
      else w = 30'(w + $urandom_range(0, step));
      h = wide ? 30'($urandom) : 30'($urandom_range(0, hmax));
      c = wide ? 60'({$urandom, $urandom}) : 60'($urandom_range(0, cmax));
      send_rect(k == 0, w, h, c);
    end
  endtask

  initial begin
    in_ch.valid = 0;
    in_ch.first_item = 0;
    in_ch.rect_width = 0;
    in_ch.rect_height = 0;
    in_ch.rect_cost = 0;
    out_ch.ready = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, equal slopes, out-of-order width
    send_rect(1, 0, 0, 0);
    send_rect(0, 0, 0, 0);
    send_rect(0, 5, 3, 2);
    send_rect(0, 5, 3, 1);
    send_rect(0, 5, 3, 20);
    send_rect(0, 2, 7, 0);
    send_rect(0, 9, 0, 60'hFFF_FFFF_FFFF_FFFF);
    send_rect(0, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 0);
    send_rect(0, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 60'hFFF_FFFF_FFFF_FFFF);
    send_rect(0, 30'h3FFF_FFFF, 0, 0);
    send_rect(0, 30'h1555_5555, 30'h2AAA_AAAA, 60'hAAA_AAAA_AAAA_AAAA);
    send_rect(1, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 60'hFFF_FFFF_FFFF_FFFF);
    send_rect(0, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 60'h555_5555_5555_5555);
    send_rect(1, 30'h2AAA_AAAA, 30'h1555_5555, 60'h555_5555_5555_5555);
    send_rect(0, 30'h3FFF_FFFF, 1, 1);
    send_rect(1, 1, 30'h3FFF_FFFF, 0);
    send_rect(0, 3, 30'h3FFF_FFFF, 60'h000_0000_4000_0000);
    send_rect(0, 7, 30'h2000_0000, 0);

    // concave intercepts keep every line: fill the stack past its depth
    send_rect(1, 0, 0, 0);
    for (int k = 1; k <= 1040; k++) send_rect(0, 30'(k), 0, 60'(1000 * k * k));

    for (int s = 0; s < 30; s++) begin
      case ($urandom_range(0, 3))
        0: run_chain($urandom_range(5, 40), 4, 20, 200, 0);
        1: run_chain($urandom_range(5, 40), 1000, 5000, 1_000_000, 0);
        2: run_chain($urandom_range(5, 20), 1 << 24, 0, 0, 1);
        default: run_chain($urandom_range(5, 30), 1 << 20, 1 << 20, 1 << 30, 0);
      endcase
    end
    quiet = 1;
    run_chain(100, 50, 100, 5000, 0);
    run_chain(60, 1 << 22, 0, 0, 1);

    in_ch.valid <= 1'b0;
    while (model.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (model.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
